@@ rtl/core/gbn_pkg.sv @@
// Package for the greedy box NMS block: widths, defaults, controller states,
// command and status bundles between controller and datapath.
// No dependencies.
package gbn_pkg;

  // Parameter defaults
  localparam int MaxBoxesDef      = 64;
  localparam int CoordFracBitsDef = 4;

  // Field widths
  localparam int PosW   = 16;
  localparam int SizeW  = 15;
  localparam int LabelW = 7;
  localparam int ScoreW = 16;
  localparam int ThrW   = 16;
  localparam int BoxW   = 2 * PosW + 2 * SizeW + LabelW + ScoreW;  // 85
  localparam int DataW  = ((BoxW + 7) / 8) * 8;                    // 88

  // Store widths
  localparam int CornerW = 2 * PosW;
  localparam int SzW     = 2 * SizeW;
  localparam int LsW     = LabelW + ScoreW;

  // Geometry widths
  localparam int EdgeW  = PosW + 2;         // signed edge and overlap span
  localparam int AreaW  = 2 * SizeW;        // unsigned area
  localparam int InterW = 2 * (EdgeW - 1);  // unsigned overlap product
  localparam int UniW   = InterW + 2;       // signed union
  localparam int ProdW  = InterW + ThrW;    // compare width

  localparam logic [ThrW-1:0] ThrReset = 16'd42598;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SRT_RDI,
    ST_SRT_LATI,
    ST_SRT_RDJ,
    ST_SRT_CMP,
    ST_SRT_WR,
    ST_SUP_RDO,
    ST_SUP_RDC,
    ST_SUP_LATC,
    ST_SUP_CHK,
    ST_SUP_RDK,
    ST_SUP_RDKB,
    ST_SUP_GEO,
    ST_SUP_MUL,
    ST_SUP_UNI,
    ST_SUP_THR,
    ST_SUP_DEC,
    ST_SUP_ADD,
    ST_SUP_NEXT,
    ST_EMT_RDL,
    ST_EMT_RDB,
    ST_EMT_LD,
    ST_EMT_OUT
  } state_e;

  // Source of the box store read address
  typedef enum logic [1:0] {
    BOX_I,
    BOX_J,
    BOX_SORTED,
    BOX_LIST
  } box_sel_e;

  typedef struct packed {
    logic     load_en;
    logic     clr_i;
    logic     inc_i;
    logic     clr_j;
    logic     inc_j;
    box_sel_e box_sel;
    logic     lat_iscore;
    logic     cmp_rank;
    logic     wr_sorted;
    logic     lat_cidx;
    logic     lat_cand;
    logic     geo;
    logic     mul;
    logic     uni;
    logic     thr_mul;
    logic     wr_list;
    logic     out_load;
    logic     clear_set;
  } cmd_t;

  typedef struct packed {
    logic i_last;
    logic j_last;
    logic j_eq_kn;
    logic j_last_kept;
    logic sup;
  } status_t;

endpackage

@@ rtl/core/gbn_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/gbn_ctrl.sv @@
// Controller for the greedy box NMS block: load, rank sort, suppression walk
// and result emission. Depends on gbn_pkg.
module gbn_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  input  logic            s_tlast_i,
  output logic            s_tready_o,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  input  gbn_pkg::status_t sts_i,
  output gbn_pkg::cmd_t    cmd_o
);

  gbn_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbn_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbn_pkg::ST_LOAD:     if (s_tvalid_i && s_tlast_i) state_d = gbn_pkg::ST_SRT_RDI;
      gbn_pkg::ST_SRT_RDI:  state_d = gbn_pkg::ST_SRT_LATI;
      gbn_pkg::ST_SRT_LATI: state_d = gbn_pkg::ST_SRT_RDJ;
      gbn_pkg::ST_SRT_RDJ:  state_d = gbn_pkg::ST_SRT_CMP;
      gbn_pkg::ST_SRT_CMP:
        state_d = sts_i.j_last ? gbn_pkg::ST_SRT_WR : gbn_pkg::ST_SRT_RDJ;
      gbn_pkg::ST_SRT_WR:
        state_d = sts_i.i_last ? gbn_pkg::ST_SUP_RDO : gbn_pkg::ST_SRT_RDI;
      gbn_pkg::ST_SUP_RDO:  state_d = gbn_pkg::ST_SUP_RDC;
      gbn_pkg::ST_SUP_RDC:  state_d = gbn_pkg::ST_SUP_LATC;
      gbn_pkg::ST_SUP_LATC: state_d = gbn_pkg::ST_SUP_CHK;
      gbn_pkg::ST_SUP_CHK:
        state_d = sts_i.j_eq_kn ? gbn_pkg::ST_SUP_ADD : gbn_pkg::ST_SUP_RDK;
      gbn_pkg::ST_SUP_RDK:  state_d = gbn_pkg::ST_SUP_RDKB;
      gbn_pkg::ST_SUP_RDKB: state_d = gbn_pkg::ST_SUP_GEO;
      gbn_pkg::ST_SUP_GEO:  state_d = gbn_pkg::ST_SUP_MUL;
      gbn_pkg::ST_SUP_MUL:  state_d = gbn_pkg::ST_SUP_UNI;
      gbn_pkg::ST_SUP_UNI:  state_d = gbn_pkg::ST_SUP_THR;
      gbn_pkg::ST_SUP_THR:  state_d = gbn_pkg::ST_SUP_DEC;
      gbn_pkg::ST_SUP_DEC:
        state_d = sts_i.sup ? gbn_pkg::ST_SUP_NEXT : gbn_pkg::ST_SUP_CHK;
      gbn_pkg::ST_SUP_ADD:  state_d = gbn_pkg::ST_SUP_NEXT;
      gbn_pkg::ST_SUP_NEXT:
        state_d = sts_i.i_last ? gbn_pkg::ST_EMT_RDL : gbn_pkg::ST_SUP_RDO;
      gbn_pkg::ST_EMT_RDL:  state_d = gbn_pkg::ST_EMT_RDB;
      gbn_pkg::ST_EMT_RDB:  state_d = gbn_pkg::ST_EMT_LD;
      gbn_pkg::ST_EMT_LD:   state_d = gbn_pkg::ST_EMT_OUT;
      gbn_pkg::ST_EMT_OUT:
        if (m_tready_i) begin
          state_d = sts_i.j_last_kept ? gbn_pkg::ST_LOAD : gbn_pkg::ST_EMT_RDL;
        end
      default:              state_d = gbn_pkg::ST_LOAD;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.box_sel = gbn_pkg::BOX_I;
    s_tready_o    = 1'b0;
    m_tvalid_o    = 1'b0;
    unique case (state_q)
      gbn_pkg::ST_LOAD: begin
        s_tready_o    = 1'b1;
        cmd_o.load_en = s_tvalid_i;
        cmd_o.clr_i   = s_tvalid_i && s_tlast_i;
      end
      gbn_pkg::ST_SRT_RDI: cmd_o.box_sel = gbn_pkg::BOX_I;
      gbn_pkg::ST_SRT_LATI: begin
        cmd_o.lat_iscore = 1'b1;
        cmd_o.clr_j      = 1'b1;
      end
      gbn_pkg::ST_SRT_RDJ: cmd_o.box_sel = gbn_pkg::BOX_J;
      gbn_pkg::ST_SRT_CMP: begin
        cmd_o.cmp_rank = 1'b1;
        cmd_o.inc_j    = 1'b1;
      end
      gbn_pkg::ST_SRT_WR: begin
        cmd_o.wr_sorted = 1'b1;
        cmd_o.inc_i     = 1'b1;
        cmd_o.clr_i     = sts_i.i_last;
      end
      gbn_pkg::ST_SUP_RDO: cmd_o.box_sel = gbn_pkg::BOX_I;
      gbn_pkg::ST_SUP_RDC: begin
        cmd_o.box_sel  = gbn_pkg::BOX_SORTED;
        cmd_o.lat_cidx = 1'b1;
      end
      gbn_pkg::ST_SUP_LATC: begin
        cmd_o.lat_cand = 1'b1;
        cmd_o.clr_j    = 1'b1;
      end
      gbn_pkg::ST_SUP_CHK: cmd_o.box_sel = gbn_pkg::BOX_LIST;
      gbn_pkg::ST_SUP_RDK: cmd_o.box_sel = gbn_pkg::BOX_LIST;
      gbn_pkg::ST_SUP_RDKB: cmd_o.box_sel = gbn_pkg::BOX_LIST;
      gbn_pkg::ST_SUP_GEO: cmd_o.geo = 1'b1;
      gbn_pkg::ST_SUP_MUL: cmd_o.mul = 1'b1;
      gbn_pkg::ST_SUP_UNI: cmd_o.uni = 1'b1;
      gbn_pkg::ST_SUP_THR: cmd_o.thr_mul = 1'b1;
      gbn_pkg::ST_SUP_DEC: cmd_o.inc_j = !sts_i.sup;
      gbn_pkg::ST_SUP_ADD: cmd_o.wr_list = 1'b1;
      gbn_pkg::ST_SUP_NEXT: begin
        cmd_o.inc_i = 1'b1;
        cmd_o.clr_j = sts_i.i_last;
      end
      gbn_pkg::ST_EMT_RDL: cmd_o.box_sel = gbn_pkg::BOX_LIST;
      gbn_pkg::ST_EMT_RDB: cmd_o.box_sel = gbn_pkg::BOX_LIST;
      gbn_pkg::ST_EMT_LD: cmd_o.out_load = 1'b1;
      gbn_pkg::ST_EMT_OUT: begin
        m_tvalid_o      = 1'b1;
        cmd_o.inc_j     = m_tready_i;
        cmd_o.clear_set = m_tready_i && sts_i.j_last_kept;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/core/gbn_datapath.sv @@
// Datapath for the greedy box NMS block: box stores, sort order, kept list,
// loop counters, IoU arithmetic and the output register. Depends on gbn_pkg, gbn_ram.
module gbn_datapath #(
  parameter int MAX_BOXES       = gbn_pkg::MaxBoxesDef,
  parameter int COORD_FRAC_BITS = gbn_pkg::CoordFracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gbn_pkg::cmd_t              cmd_i,
  output gbn_pkg::status_t           sts_o,
  input  logic                       cfg_we_i,
  input  logic [gbn_pkg::ThrW-1:0]   cfg_thr_i,
  input  logic [gbn_pkg::BoxW-1:0]   in_box_i,
  output logic [gbn_pkg::BoxW-1:0]   out_box_o,
  output logic                       out_last_o,
  output logic                       out_ovf_o
);

  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_BOXES);
  localparam logic signed [gbn_pkg::EdgeW-1:0] Pixel =
    gbn_pkg::EdgeW'(1 << COORD_FRAC_BITS);

  localparam int PW = gbn_pkg::PosW;
  localparam int SW = gbn_pkg::SizeW;

  // Control registers
  logic [CW-1:0]  cnt_q, i_q, j_q, kn_q, rank_q;
  logic           ovf_q;
  logic [gbn_pkg::ThrW-1:0] thr_q;

  // Store read side
  logic [IW-1:0]  box_raddr;
  logic [gbn_pkg::CornerW-1:0] corner_rd;
  logic [gbn_pkg::SzW-1:0]     size_rd;
  logic [gbn_pkg::LsW-1:0]     ls_rd;
  logic [IW-1:0]  sorted_rd, list_rd;
  logic           box_we;

  // Candidate and arithmetic registers
  logic [gbn_pkg::ScoreW-1:0]   iscore_q;
  logic [IW-1:0]                cidx_q;
  logic signed [PW-1:0]         cx_q, cy_q;
  logic [SW-1:0]                cw_q, ch_q;
  logic [gbn_pkg::AreaW-1:0]    carea_q, karea_q;
  logic signed [gbn_pkg::EdgeW-1:0] h_q, w_q;
  logic [gbn_pkg::InterW-1:0]   inter_q;
  logic signed [gbn_pkg::UniW-1:0] uni_q;
  logic [gbn_pkg::ProdW-1:0]    prod_q;

  // Kept box fields from the store
  logic signed [PW-1:0] kx, ky;
  logic [SW-1:0]        kw, kh;
  logic signed [gbn_pkg::EdgeW-1:0] x0, y0, x1, y1, ax1, ay1, bx1, by1, h_d, w_d;
  logic [gbn_pkg::ScoreW-1:0] jscore;
  logic                 ahead;
  logic [gbn_pkg::ProdW-1:0] inter_sh;

  assign box_we = cmd_i.load_en && (cnt_q < MaxCnt);

  // Select the box store read address
  always_comb begin
    case (cmd_i.box_sel)
      gbn_pkg::BOX_I:      box_raddr = i_q[IW-1:0];
      gbn_pkg::BOX_J:      box_raddr = j_q[IW-1:0];
      gbn_pkg::BOX_SORTED: box_raddr = sorted_rd;
      gbn_pkg::BOX_LIST:   box_raddr = list_rd;
      default:             box_raddr = i_q[IW-1:0];
    endcase
  end

  gbn_ram #(.WIDTH(gbn_pkg::CornerW), .DEPTH(MAX_BOXES)) u_corner (
    .clk_i, .we_i(box_we), .waddr_i(cnt_q[IW-1:0]),
    .wdata_i(in_box_i[2*PW-1:0]), .raddr_i(box_raddr), .rdata_o(corner_rd)
  );

  gbn_ram #(.WIDTH(gbn_pkg::SzW), .DEPTH(MAX_BOXES)) u_size (
    .clk_i, .we_i(box_we), .waddr_i(cnt_q[IW-1:0]),
    .wdata_i(in_box_i[2*PW+2*SW-1:2*PW]), .raddr_i(box_raddr), .rdata_o(size_rd)
  );

  gbn_ram #(.WIDTH(gbn_pkg::LsW), .DEPTH(MAX_BOXES)) u_label_score (
    .clk_i, .we_i(box_we), .waddr_i(cnt_q[IW-1:0]),
    .wdata_i(in_box_i[gbn_pkg::BoxW-1:2*PW+2*SW]), .raddr_i(box_raddr),
    .rdata_o(ls_rd)
  );

  // Sorted order: written at the rank, read at the walk position
  gbn_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_sorted (
    .clk_i, .we_i(cmd_i.wr_sorted), .waddr_i(rank_q[IW-1:0]),
    .wdata_i(i_q[IW-1:0]), .raddr_i(i_q[IW-1:0]), .rdata_o(sorted_rd)
  );

  // Kept list in score order
  gbn_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_kept (
    .clk_i, .we_i(cmd_i.wr_list), .waddr_i(kn_q[IW-1:0]),
    .wdata_i(cidx_q), .raddr_i(j_q[IW-1:0]), .rdata_o(list_rd)
  );

  // Unpack the store read data (label_score holds label low, score high)
  assign kx     = corner_rd[PW-1:0];
  assign ky     = corner_rd[2*PW-1:PW];
  assign kw     = size_rd[SW-1:0];
  assign kh     = size_rd[2*SW-1:SW];
  assign jscore = ls_rd[gbn_pkg::LsW-1:gbn_pkg::LabelW];

  // Overlap spans with the one pixel convention
  always_comb begin
    ax1 = gbn_pkg::EdgeW'(cx_q) + gbn_pkg::EdgeW'({1'b0, cw_q});
    ay1 = gbn_pkg::EdgeW'(cy_q) + gbn_pkg::EdgeW'({1'b0, ch_q});
    bx1 = gbn_pkg::EdgeW'(kx) + gbn_pkg::EdgeW'({1'b0, kw});
    by1 = gbn_pkg::EdgeW'(ky) + gbn_pkg::EdgeW'({1'b0, kh});
    x0  = (cx_q > kx) ? gbn_pkg::EdgeW'(cx_q) : gbn_pkg::EdgeW'(kx);
    y0  = (cy_q > ky) ? gbn_pkg::EdgeW'(cy_q) : gbn_pkg::EdgeW'(ky);
    x1  = (ax1 < bx1) ? ax1 : bx1;
    y1  = (ay1 < by1) ? ay1 : by1;
    h_d = y1 - y0 + Pixel;
    w_d = x1 - x0 + Pixel;
  end

  // Rank test: a higher score, or an equal score that arrived earlier
  assign ahead = (jscore > iscore_q) || ((jscore == iscore_q) && (j_q < i_q));

  assign inter_sh = {inter_q, {gbn_pkg::ThrW{1'b0}}};

  // Status
  assign sts_o.i_last      = ({1'b0, i_q} + 1'b1) == {1'b0, cnt_q};
  assign sts_o.j_last      = ({1'b0, j_q} + 1'b1) == {1'b0, cnt_q};
  assign sts_o.j_eq_kn     = (j_q == kn_q);
  assign sts_o.j_last_kept = ({1'b0, j_q} + 1'b1) == {1'b0, kn_q};
  assign sts_o.sup         = (inter_q != '0) &&
                             ((uni_q == '0) || (!uni_q[gbn_pkg::UniW-1] && (inter_sh > prod_q)));

  // Counters, set state and threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      kn_q   <= '0;
      i_q    <= '0;
      j_q    <= '0;
      rank_q <= '0;
      thr_q  <= gbn_pkg::ThrReset;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_thr_i;
      end
      if (cmd_i.load_en) begin
        if (cnt_q < MaxCnt) begin
          cnt_q <= cnt_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.clr_i) begin
        i_q <= '0;
      end else if (cmd_i.inc_i) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.clr_j) begin
        j_q <= '0;
      end else if (cmd_i.inc_j) begin
        j_q <= j_q + 1'b1;
      end
      if (cmd_i.lat_iscore) begin
        rank_q <= '0;
      end else if (cmd_i.cmp_rank && ahead) begin
        rank_q <= rank_q + 1'b1;
      end
      if (cmd_i.wr_list) begin
        kn_q <= kn_q + 1'b1;
      end
      if (cmd_i.clear_set) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
        kn_q  <= '0;
        j_q   <= '0;
      end
    end
  end

  // Candidate latch and IoU stages
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_iscore) begin
      iscore_q <= jscore;
    end
    if (cmd_i.lat_cidx) begin
      cidx_q <= sorted_rd;
    end
    if (cmd_i.lat_cand) begin
      cx_q    <= kx;
      cy_q    <= ky;
      cw_q    <= kw;
      ch_q    <= kh;
      carea_q <= kw * kh;
    end
    if (cmd_i.geo) begin
      h_q     <= h_d;
      w_q     <= w_d;
      karea_q <= kw * kh;
    end
    if (cmd_i.mul) begin
      if (h_q[gbn_pkg::EdgeW-1] || w_q[gbn_pkg::EdgeW-1]) begin
        inter_q <= '0;
      end else begin
        inter_q <= h_q[gbn_pkg::EdgeW-2:0] * w_q[gbn_pkg::EdgeW-2:0];
      end
    end
    if (cmd_i.uni) begin
      uni_q <= gbn_pkg::UniW'({2'b0, carea_q}) + gbn_pkg::UniW'({2'b0, karea_q})
             - gbn_pkg::UniW'({2'b0, inter_q});
    end
    if (cmd_i.thr_mul) begin
      prod_q <= thr_q * uni_q[gbn_pkg::InterW-1:0];
    end
    if (cmd_i.out_load) begin
      out_box_o  <= {ls_rd, size_rd, corner_rd};
      out_last_o <= sts_o.j_last_kept;
      out_ovf_o  <= ovf_q;
    end
  end

endmodule

@@ rtl/core/greedy_box_nms_top.sv @@
// Top level of the greedy box NMS block: stream ports, controller and datapath.
// Depends on gbn_pkg, gbn_ctrl, gbn_datapath, gbn_ram.
//
// Channel  Dir  Handshake                 Payload
// s_axis   in   s_tvalid_i / s_tready_o   s_tdata_i (box), s_tlast_i (final_box)
// m_axis   out  m_tvalid_o / m_tready_i   m_tdata_o (kept box), m_tlast_o, m_tuser_o
// cfg      in   cfg_valid_i / cfg_ready_o cfg_data_i (iou_threshold)
//
// Loading takes one request per cycle. After the final request, the block
// ranks the set by score, then checks each candidate against the kept boxes,
// then emits each result. The single read port of each box store sets the pace
// of ranking, suppression and emission. Reset empties the set and loads the
// threshold with 0.65; no input is taken until the results of a set have all
// been taken by the sink.
module greedy_box_nms_top #(
  parameter int MAX_BOXES       = gbn_pkg::MaxBoxesDef,
  parameter int COORD_FRAC_BITS = gbn_pkg::CoordFracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Fields from bit 0: box_x, box_y, box_width, box_height, class_label, score
  input  logic [gbn_pkg::DataW-1:0] s_tdata_i,
  input  logic                      s_tlast_i,
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  // Fields from bit 0: kept_x, kept_y, kept_width, kept_height, kept_label, kept_score
  output logic [gbn_pkg::DataW-1:0] m_tdata_o,
  output logic                      m_tlast_o,
  // Fields from bit 0: overflowed
  output logic                      m_tuser_o,
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  input  logic [gbn_pkg::ThrW-1:0]  cfg_data_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o
);

  gbn_pkg::cmd_t    cmd;
  gbn_pkg::status_t sts;
  logic [gbn_pkg::BoxW-1:0] out_box;

  // Accept threshold writes at any time
  assign cfg_ready_o = 1'b1;

  // Pad the result to whole bytes
  assign m_tdata_o = gbn_pkg::DataW'(out_box);

  gbn_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .s_tvalid_i, .s_tlast_i, .s_tready_o,
    .m_tvalid_o, .m_tready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  gbn_datapath #(
    .MAX_BOXES(MAX_BOXES),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_datapath (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i(cfg_valid_i), .cfg_thr_i(cfg_data_i),
    .in_box_i(s_tdata_i[gbn_pkg::BoxW-1:0]),
    .out_box_o(out_box), .out_last_o(m_tlast_o), .out_ovf_o(m_tuser_o)
  );

endmodule
